/* src/m3i_pkg.sv */
// Shared constants for the 3x3 matrix inverse pipeline.
// No dependencies; used by every module of the block.
`default_nettype none

package m3i_pkg;

	localparam int ELEM_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int DIM        = 3;
	localparam int NUM_ELEMS  = DIM * DIM;
	localparam int COF_STAGES = 5;

endpackage

`default_nettype wire

/* src/m3i_cofdet.sv */
// Cofactor and determinant stages: five register stages with per-stage valid.
// Depends on m3i_pkg.
`default_nettype none

module m3i_cofdet #(
	parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [ELEM_WIDTH-1:0]  elem [m3i_pkg::NUM_ELEMS],
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [2*ELEM_WIDTH:0]       cof [m3i_pkg::NUM_ELEMS],
	output logic signed [3*ELEM_WIDTH+2:0]     det
);

	localparam int W  = ELEM_WIDTH;
	localparam int PW = 2 * W;
	localparam int CW = 2 * W + 1;
	localparam int TW = 3 * W + 1;
	localparam int DW = 3 * W + 3;
	localparam int NS = m3i_pkg::COF_STAGES;
	localparam int N  = m3i_pkg::NUM_ELEMS;
	localparam int D  = m3i_pkg::DIM;

	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;

	logic signed [PW-1:0] pa_s1 [N];
	logic signed [PW-1:0] pb_s1 [N];
	logic signed [W-1:0]  a0_s1 [D];
	logic signed [CW-1:0] cof_s2 [N];
	logic signed [W-1:0]  a0_s2 [D];
	logic signed [CW-1:0] cof_s3 [N];
	logic signed [CW-1:0] plo_s3 [D];
	logic signed [CW-1:0] phi_s3 [D];
	logic signed [CW-1:0] cof_s4 [N];
	logic signed [TW-1:0] term_s4 [D];
	logic signed [CW-1:0] cof_s5 [N];
	logic signed [DW-1:0] det_s5;

	always_comb begin
		rdy[NS] = !out_stall;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[NS-1];
	assign cof       = cof_s5;
	assign det       = det_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[k-1];
				end
			end
		end
	end

	// elem is column-major: row r, column c at c*3+r; cofactors are stored r*3+c
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			for (int r = 0; r < D; r++) begin
				for (int c = 0; c < D; c++) begin
					pa_s1[r*D+c] <= elem[((c+1)%D)*D + (r+1)%D] * elem[((c+2)%D)*D + (r+2)%D];
					pb_s1[r*D+c] <= elem[((c+2)%D)*D + (r+1)%D] * elem[((c+1)%D)*D + (r+2)%D];
				end
			end
			for (int c = 0; c < D; c++) begin
				a0_s1[c] <= elem[c*D];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int i = 0; i < N; i++) begin
				cof_s2[i] <= {pa_s1[i][PW-1], pa_s1[i]} - {pb_s1[i][PW-1], pb_s1[i]};
			end
			a0_s2 <= a0_s1;
		end
	end

	// split each row-0 cofactor into an unsigned low word and a signed high part
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			cof_s3 <= cof_s2;
			for (int c = 0; c < D; c++) begin
				plo_s3[c] <= a0_s2[c] * $signed({1'b0, cof_s2[c][W-1:0]});
				phi_s3[c] <= a0_s2[c] * $signed(cof_s2[c][CW-1:W]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			cof_s4 <= cof_s3;
			for (int c = 0; c < D; c++) begin
				term_s4[c] <= {phi_s3[c], {W{1'b0}}} + {{W{plo_s3[c][CW-1]}}, plo_s3[c]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			cof_s5 <= cof_s4;
			det_s5 <= {{2{term_s4[0][TW-1]}}, term_s4[0]}
				+ {{2{term_s4[1][TW-1]}}, term_s4[1]}
				+ {{2{term_s4[2][TW-1]}}, term_s4[2]};
		end
	end

endmodule

`default_nettype wire

/* src/m3i_divider.sv */
// Nine-lane pipelined restoring divider: one quotient bit per stage, then saturation.
// Depends on m3i_pkg.
`default_nettype none

module m3i_divider #(
	parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH,
	parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [2*ELEM_WIDTH:0]    cof [m3i_pkg::NUM_ELEMS],
	input  wire logic signed [3*ELEM_WIDTH+2:0]  det,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [ELEM_WIDTH-1:0]         quot [m3i_pkg::NUM_ELEMS],
	output logic                                 singular
);

	localparam int W   = ELEM_WIDTH;
	localparam int CW  = 2 * W + 1;
	localparam int DW  = 3 * W + 3;
	localparam int NMW = CW + 2 * FRAC_BITS;
	localparam int RW  = (NMW > DW + W) ? NMW : DW + W;
	localparam int NS  = W + 3;
	localparam int N   = m3i_pkg::NUM_ELEMS;
	localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;

	logic [NMW-1:0] nmag_s0 [N];
	logic [RW-1:0]  rem_s  [1:W+1][N];
	logic [W-1:0]   q_s    [1:W+1][N];
	logic           big_s  [1:W+1][N];
	logic           sgn_s  [0:W+1][N];
	logic [DW-1:0]  dmag_s [0:W+1];
	logic           sing_s [0:W+1];
	logic signed [W-1:0] quot_sx [N];
	logic           sing_sx;

	always_comb begin
		rdy[NS] = !out_stall;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[NS-1];
	assign quot      = quot_sx;
	assign singular  = sing_sx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[k-1];
				end
			end
		end
	end

	// magnitudes and signs; numerator carries the 2*FRAC_BITS scale
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			dmag_s[0] <= det[DW-1] ? DW'(-det) : DW'(det);
			sing_s[0] <= (det == '0);
			for (int l = 0; l < N; l++) begin
				nmag_s0[l] <= {(cof[l][CW-1] ? CW'(-cof[l]) : CW'(cof[l])),
					{(2*FRAC_BITS){1'b0}}};
				sgn_s[0][l] <= cof[l][CW-1] ^ det[DW-1];
			end
		end
	end

	// flag quotients that cannot fit in W bits
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			dmag_s[1] <= dmag_s[0];
			sing_s[1] <= sing_s[0];
			for (int l = 0; l < N; l++) begin
				rem_s[1][l] <= RW'(nmag_s0[l]);
				q_s[1][l]   <= '0;
				big_s[1][l] <= RW'(nmag_s0[l]) >= (RW'(dmag_s[0]) << W);
				sgn_s[1][l] <= sgn_s[0][l];
			end
		end
	end

	for (genvar k = 2; k <= W + 1; k++) begin : g_bit
		localparam int B = W + 1 - k;
		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				dmag_s[k] <= dmag_s[k-1];
				sing_s[k] <= sing_s[k-1];
				for (int l = 0; l < N; l++) begin
					big_s[k][l] <= big_s[k-1][l];
					sgn_s[k][l] <= sgn_s[k-1][l];
					if (rem_s[k-1][l] >= (RW'(dmag_s[k-1]) << B)) begin
						rem_s[k][l] <= rem_s[k-1][l] - (RW'(dmag_s[k-1]) << B);
						q_s[k][l]   <= q_s[k-1][l] | (W'(1) << B);
					end else begin
						rem_s[k][l] <= rem_s[k-1][l];
						q_s[k][l]   <= q_s[k-1][l];
					end
				end
			end
		end
	end

	// saturate, apply sign, force zero on a singular matrix
	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			sing_sx <= sing_s[W+1];
			for (int l = 0; l < N; l++) begin
				if (sing_s[W+1]) begin
					quot_sx[l] <= '0;
				end else if (sgn_s[W+1][l]) begin
					if (big_s[W+1][l] || q_s[W+1][l] > HALF) begin
						quot_sx[l] <= HALF;
					end else begin
						quot_sx[l] <= W'(0) - q_s[W+1][l];
					end
				end else if (big_s[W+1][l] || q_s[W+1][l][W-1]) begin
					quot_sx[l] <= ~HALF;
				end else begin
					quot_sx[l] <= q_s[W+1][l];
				end
			end
		end
	end

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> quot_sx[0] == '0 && quot_sx[4] == '0 && quot_sx[8] == '0)
		else $error("singular result carries nonzero data");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> &vld_q && out_stall)
		else $error("input stalled while a stage is empty");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[0])
		else $error("accepted transaction not captured");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sing_sx))
		else $error("stalled result dropped");

endmodule

`default_nettype wire

/* src/matrix3_inverse.sv */
// 3x3 fixed-point matrix inverse by adjugate; top level.
// Depends on m3i_pkg, m3i_cofdet and m3i_divider.
//
// Usage: present nine signed elements (column-major, Q(W-F).F) with in_valid;
// the matrix is taken at a clock edge where in_valid is high and in_stall low.
// The result leaves on out_c*_r* with singular, under out_valid; the receiver
// holds out_stall high to keep it. singular is set, with all outputs zero,
// when the determinant is exactly zero; otherwise each element is the
// truncated quotient cofactor * 2^(2F) / det, saturated to ELEM_WIDTH bits.
// Pipeline: five stages of cofactor and determinant products, then a
// restoring divider that resolves one quotient bit per stage in nine lanes,
// then one saturation stage. Throughput: one matrix per cycle while in_stall
// is low. Each stage loads whenever it is empty or its content moves on, so
// a stalled receiver only stops input once every stage is full; empty
// stages keep filling meanwhile.
// Reset clears all valid bits; no clearing pass is needed.
`default_nettype none

module matrix3_inverse #(
	parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH,
	parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [ELEM_WIDTH-1:0] in_c0_r0,
	input  wire logic signed [ELEM_WIDTH-1:0] in_c0_r1,
	input  wire logic signed [ELEM_WIDTH-1:0] in_c0_r2,
	input  wire logic signed [ELEM_WIDTH-1:0] in_c1_r0,
	input  wire logic signed [ELEM_WIDTH-1:0] in_c1_r1,
	input  wire logic signed [ELEM_WIDTH-1:0] in_c1_r2,
	input  wire logic signed [ELEM_WIDTH-1:0] in_c2_r0,
	input  wire logic signed [ELEM_WIDTH-1:0] in_c2_r1,
	input  wire logic signed [ELEM_WIDTH-1:0] in_c2_r2,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [ELEM_WIDTH-1:0]      out_c0_r0,
	output logic signed [ELEM_WIDTH-1:0]      out_c0_r1,
	output logic signed [ELEM_WIDTH-1:0]      out_c0_r2,
	output logic signed [ELEM_WIDTH-1:0]      out_c1_r0,
	output logic signed [ELEM_WIDTH-1:0]      out_c1_r1,
	output logic signed [ELEM_WIDTH-1:0]      out_c1_r2,
	output logic signed [ELEM_WIDTH-1:0]      out_c2_r0,
	output logic signed [ELEM_WIDTH-1:0]      out_c2_r1,
	output logic signed [ELEM_WIDTH-1:0]      out_c2_r2,
	output logic                              singular
);

	localparam int N = m3i_pkg::NUM_ELEMS;

	logic signed [ELEM_WIDTH-1:0]   elem [N];
	logic signed [2*ELEM_WIDTH:0]   cof  [N];
	logic signed [3*ELEM_WIDTH+2:0] det;
	logic signed [ELEM_WIDTH-1:0]   quot [N];
	logic                           mid_valid;
	logic                           mid_stall;

	assign elem[0] = in_c0_r0;
	assign elem[1] = in_c0_r1;
	assign elem[2] = in_c0_r2;
	assign elem[3] = in_c1_r0;
	assign elem[4] = in_c1_r1;
	assign elem[5] = in_c1_r2;
	assign elem[6] = in_c2_r0;
	assign elem[7] = in_c2_r1;
	assign elem[8] = in_c2_r2;

	m3i_cofdet #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_cofdet (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.elem      (elem),
		.out_valid (mid_valid),
		.out_stall (mid_stall),
		.cof       (cof),
		.det       (det)
	);

	// cofactor r*3+c over det lands at column r, row c, index r*3+c
	m3i_divider #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_stall  (mid_stall),
		.cof       (cof),
		.det       (det),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.quot      (quot),
		.singular  (singular)
	);

	assign out_c0_r0 = quot[0];
	assign out_c0_r1 = quot[1];
	assign out_c0_r2 = quot[2];
	assign out_c1_r0 = quot[3];
	assign out_c1_r1 = quot[4];
	assign out_c1_r2 = quot[5];
	assign out_c2_r0 = quot[6];
	assign out_c2_r1 = quot[7];
	assign out_c2_r2 = quot[8];

endmodule

`default_nettype wire
